// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the radix text unit.
// Expects clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is held.
`define SIRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define SIRT_NEVER(lbl, cond, msg) \
  `SIRT_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/sirt_pkg.sv =====
// Shared types, constants and symbol lookup for the radix text unit.
// No dependencies.
package sirt_pkg;

  localparam int unsigned WORD_COUNT = 8;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned WORD_IW    = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned SYM_COUNT  = 64;
  localparam int unsigned SYM_IDX_W  = 6;
  localparam int unsigned SYM_CNT_W  = 7;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef logic [WORD_COUNT-1:0][WORD_W-1:0] alph_words_t;

  // Alphabet check status
  typedef struct packed {
    logic                 valid;
    logic                 bad;
    logic [SYM_CNT_W-1:0] len;
  } chk_sts_t;

  // Digit unit command
  typedef struct packed {
    logic clear;
    logic dbl;
    logic din;
    logic shift;
  } dig_cmd_t;

  // Byte k of the alphabet sits in word k/8, bits 8*(k%8)+7..8*(k%8).
  function automatic logic [7:0] sym_at(alph_words_t words, logic [SYM_IDX_W-1:0] idx);
    return words[idx[SYM_IDX_W-1:WORD_IW]][{idx[WORD_IW-1:0], 3'b000} +: 8];
  endfunction

endpackage

// ===== hw/rtl/signed_integer_to_radix_text_unit.sv =====
// Signed integer to text in a configurable radix. Each number taken on the
// input channel comes out as an optional '-' and then its digits, most
// significant first, one byte per output transaction, with last on the final
// byte. The digit alphabet lives in eight 64-bit registers and ends at the
// first zero byte; its length is the radix. If the alphabet is shorter than
// two symbols, holds '+' or '-', or repeats a symbol, a number yields a single
// byte 0 with last and invalid set. Timing: after any configuration write the
// alphabet is rescanned at one symbol per cycle (overlapped with idle time; an
// item arriving earlier waits for it). Each item then occupies the unit for
// bit-serial conversion in the shared double-and-add digit unit, for a '-' byte
// if the number is negative, and for the readout of NUMBER_WIDTH digit
// positions, one digit position per cycle while the output does not stall.
// in_stall_o is high for the whole of that time. Depends on sirt_pkg and
// assert_macros.svh.
`include "assert_macros.svh"

module signed_integer_to_radix_text_unit #(
  parameter int unsigned ALPHABET_CAPACITY = 64,
  parameter int unsigned NUMBER_WIDTH      = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sirt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sirt_pkg::WORD_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [NUMBER_WIDTH-1:0]      number_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          character_o,
  output logic                                last_o,
  output logic                                invalid_o
);
  import sirt_pkg::*;

  localparam int unsigned DW = $clog2(ALPHABET_CAPACITY);
  localparam int unsigned LW = $clog2(ALPHABET_CAPACITY + 1);
  localparam int unsigned CW = $clog2(NUMBER_WIDTH + 1);
  localparam int unsigned PW = $clog2(NUMBER_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CONV,
    S_SIGN,
    S_EMIT,
    S_BAD
  } state_e;

  state_e                  state_q, state_d;
  alph_words_t             alph_q;
  logic [NUMBER_WIDTH-1:0] mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic [PW-1:0]           cnt_q, cnt_d;
  logic                    ov_q, ov_d;
  logic [7:0]              char_q, char_d;
  logic                    last_q, last_d;
  logic                    inv_q, inv_d;

  chk_sts_t                chk_sts;
  dig_cmd_t                dig_cmd;
  logic [DW-1:0]           top_digit;
  logic [CW-1:0]           ndig;
  logic                    cfg_wr, in_acc, out_free, emit_now;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(WORD_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alph_q <= '0;
    end else if (cfg_wr) begin
      alph_q[cfg_index_i[WORD_IW-1:0]] <= cfg_data_i;
    end
  end

  sirt_alpha_chk #(
    .ALPHABET_CAPACITY(ALPHABET_CAPACITY)
  ) u_chk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(cfg_wr),
    .alph_i (alph_q),
    .sts_o  (chk_sts)
  );

  sirt_digit_unit #(
    .ALPHABET_CAPACITY(ALPHABET_CAPACITY),
    .NUMBER_WIDTH     (NUMBER_WIDTH)
  ) u_dig (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dig_cmd),
    .radix_i    (LW'(chk_sts.len)),
    .top_digit_o(top_digit),
    .ndig_o     (ndig)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;
  // In readout cnt_q is the digit position now at the top of the register.
  assign emit_now   = (CW'(cnt_q) < ndig);

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && out_stall_i;
    char_d  = char_q;
    last_d  = last_q;
    inv_d   = inv_q;
    dig_cmd = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          neg_d         = number_i[NUMBER_WIDTH-1];
          mag_d         = number_i[NUMBER_WIDTH-1] ? -number_i : number_i;
          cnt_d         = '0;
          dig_cmd.clear = 1'b1;
          if (!chk_sts.valid) begin
            state_d = S_SCAN;
          end else if (chk_sts.bad) begin
            state_d = S_BAD;
          end else begin
            state_d = S_CONV;
          end
        end
      end
      S_SCAN: begin
        if (chk_sts.valid) begin
          state_d = chk_sts.bad ? S_BAD : S_CONV;
        end
      end
      S_CONV: begin
        dig_cmd.dbl = 1'b1;
        dig_cmd.din = mag_q[NUMBER_WIDTH-1];
        mag_d       = mag_q << 1;
        cnt_d       = cnt_q + PW'(1);
        if (cnt_q == PW'(NUMBER_WIDTH - 1)) begin
          cnt_d   = PW'(NUMBER_WIDTH - 1);
          state_d = neg_q ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          char_d  = CHAR_MINUS;
          last_d  = 1'b0;
          inv_d   = 1'b0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!emit_now) begin
          // leading zero position, skip it
          dig_cmd.shift = 1'b1;
          cnt_d         = cnt_q - PW'(1);
        end else if (out_free) begin
          ov_d          = 1'b1;
          char_d        = sym_at(alph_q, SYM_IDX_W'(top_digit));
          last_d        = (cnt_q == '0);
          inv_d         = 1'b0;
          dig_cmd.shift = 1'b1;
          cnt_d         = cnt_q - PW'(1);
          if (cnt_q == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      S_BAD: begin
        if (out_free) begin
          ov_d    = 1'b1;
          char_d  = CHAR_NUL;
          last_d  = 1'b1;
          inv_d   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      char_q  <= '0;
      last_q  <= 1'b0;
      inv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      char_q  <= char_d;
      last_q  <= last_d;
      inv_q   <= inv_d;
    end
  end

  assign out_valid_o = ov_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign invalid_o   = inv_q;

  `SIRT_ASSERT(a_bad_alone, out_valid_o && invalid_o |-> last_o && (character_o == CHAR_NUL), "invalid result must be a lone zero byte")
  `SIRT_NEVER(a_ndig_range, ndig > CW'(NUMBER_WIDTH), "digit count exceeds number width")
  `SIRT_ASSERT(a_lead_zero, (state_q == S_EMIT) && !emit_now |-> (top_digit == '0), "nonzero digit above digit count")
  `SIRT_ASSERT(a_busy_after_acc, in_valid_i && !in_stall_o |=> in_stall_o, "transaction taken but unit not busy")

endmodule

// ===== hw/rtl/sirt_alpha_chk.sv =====
// Alphabet scanner: finds the alphabet length and flags short, signed or
// repeated alphabets, one symbol per cycle. Depends on sirt_pkg.
module sirt_alpha_chk #(
  parameter int unsigned ALPHABET_CAPACITY = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  sirt_pkg::alph_words_t alph_i,
  output sirt_pkg::chk_sts_t    sts_o
);
  import sirt_pkg::*;

  localparam int unsigned LW = $clog2(ALPHABET_CAPACITY + 1);

  logic [LW-1:0]        scan_q, scan_d;
  logic [LW-1:0]        len_q, len_d;
  logic                 valid_q, valid_d;
  logic                 bad_q, bad_d;
  logic [SYM_CNT_W-1:0] pos_w;
  logic [7:0]           sym_w;
  logic                 dup_w, sign_w, at_end_w;

  // Compare the current symbol against every earlier one in parallel.
  always_comb begin
    pos_w    = SYM_CNT_W'(scan_q);
    sym_w    = sym_at(alph_i, SYM_IDX_W'(scan_q));
    sign_w   = (sym_w == CHAR_PLUS) || (sym_w == CHAR_MINUS);
    at_end_w = (scan_q == LW'(ALPHABET_CAPACITY));
    dup_w    = 1'b0;
    for (int j = 0; j < SYM_COUNT; j++) begin
      if ((SYM_CNT_W'(j) < pos_w) && (sym_at(alph_i, SYM_IDX_W'(j)) == sym_w)) begin
        dup_w = 1'b1;
      end
    end
  end

  always_comb begin
    scan_d  = scan_q;
    len_d   = len_q;
    valid_d = valid_q;
    bad_d   = bad_q;
    if (clear_i) begin
      valid_d = 1'b0;
      scan_d  = '0;
    end else if (!valid_q) begin
      if (at_end_w) begin
        valid_d = 1'b1;
        bad_d   = 1'b0;
        len_d   = scan_q;
      end else if (sym_w == CHAR_NUL) begin
        valid_d = 1'b1;
        bad_d   = (scan_q < LW'(2));
        len_d   = scan_q;
      end else if (sign_w || dup_w) begin
        valid_d = 1'b1;
        bad_d   = 1'b1;
      end else begin
        scan_d = scan_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      len_q   <= '0;
      valid_q <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      scan_q  <= scan_d;
      len_q   <= len_d;
      valid_q <= valid_d;
      bad_q   <= bad_d;
    end
  end

  assign sts_o.valid = valid_q;
  assign sts_o.bad   = bad_q;
  assign sts_o.len   = SYM_CNT_W'(len_q);

endmodule

// ===== hw/rtl/sirt_digit_unit.sv =====
// Radix digit register with a shared double-and-add step (binary to radix,
// one input bit per cycle) and a shift toward the top for readout.
// Depends on sirt_pkg.
module sirt_digit_unit #(
  parameter int unsigned ALPHABET_CAPACITY = 64,
  parameter int unsigned NUMBER_WIDTH      = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sirt_pkg::dig_cmd_t                     cmd_i,
  input  logic [$clog2(ALPHABET_CAPACITY+1)-1:0] radix_i,
  output logic [$clog2(ALPHABET_CAPACITY)-1:0]   top_digit_o,
  output logic [$clog2(NUMBER_WIDTH+1)-1:0]      ndig_o
);
  import sirt_pkg::*;

  localparam int unsigned DW = $clog2(ALPHABET_CAPACITY);
  localparam int unsigned ND = NUMBER_WIDTH;
  localparam int unsigned CW = $clog2(ND + 1);

  logic [DW-1:0] dig_q [ND];
  logic [DW-1:0] dig_d [ND];
  logic [DW-1:0] dbl_w [ND];
  logic [DW:0]   t_w   [ND];
  logic [CW-1:0] ndig_q, ndig_d;
  logic [DW:0]   rad_w;
  logic [ND-1:0] gen_w, prop_w;
  logic [ND:0]   sum_w, carry_w;

  // Digit k doubles to 2d+c. It carries out when 2d >= r (generate) or
  // when 2d+1 == r and a carry comes in (propagate), so the carry chain
  // is an ordinary adder carry.
  always_comb begin
    rad_w = (DW+1)'(radix_i);
    for (int k = 0; k < ND; k++) begin
      gen_w[k]  = ({dig_q[k], 1'b0} >= rad_w);
      prop_w[k] = ({dig_q[k], 1'b1} == rad_w);
    end
    sum_w   = {1'b0, gen_w | prop_w} + {1'b0, gen_w} + (ND+1)'(cmd_i.din);
    carry_w = sum_w ^ {1'b0, gen_w | prop_w} ^ {1'b0, gen_w};
    for (int k = 0; k < ND; k++) begin
      t_w[k]   = {dig_q[k], carry_w[k]};
      dbl_w[k] = (t_w[k] >= rad_w) ? DW'(t_w[k] - rad_w) : DW'(t_w[k]);
    end
  end

  always_comb begin
    dig_d  = dig_q;
    ndig_d = ndig_q;
    if (cmd_i.clear) begin
      for (int k = 0; k < ND; k++) begin
        dig_d[k] = '0;
      end
      ndig_d = CW'(1);
    end else if (cmd_i.dbl) begin
      dig_d  = dbl_w;
      ndig_d = ndig_q + CW'(carry_w[ndig_q]);
    end else if (cmd_i.shift) begin
      dig_d[0] = '0;
      for (int k = 1; k < ND; k++) begin
        dig_d[k] = dig_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndig_q <= CW'(1);
    end else begin
      ndig_q <= ndig_d;
    end
  end

  assign top_digit_o = dig_q[ND-1];
  assign ndig_o      = ndig_q;

endmodule
